@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the blob decoder
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define CBPD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define CBPD_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/cbpd_pkg.sv @@
// ---------------------------------------------------------------------------
// cbpd_pkg
// types, constants and the bearing boundary table of the blob decoder
// ---------------------------------------------------------------------------
package cbpd_pkg;

    // frame layout
    localparam int FRAME_LENGTH = 11;
    localparam int IDX_W        = 5;
    localparam int NUM_FIELDS   = 9;
    localparam int NUM_OBJ      = 3;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_LENGTH - 1);

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam logic [1:0] REG_BEGIN    = 2'd0;
    localparam logic [1:0] REG_CENTRE_X = 2'd1;
    localparam logic [1:0] REG_CENTRE_Y = 2'd2;
    localparam logic [7:0] BEGIN_RESET    = 8'd11;
    localparam logic [7:0] CENTRE_X_RESET = 8'd80;
    localparam logic [7:0] CENTRE_Y_RESET = 8'd60;

    // angle arithmetic
    localparam int ANGLE_OFFSET = 450;
    localparam int FULL_TURN    = 360;
    localparam int HALF_TURN    = 180;
    localparam int QUARTER_TURN = 90;
    localparam int NUM_BOUNDS   = 45;
    localparam int BOUND_W      = 6;
    localparam int TAN_W        = 48;
    localparam int SUB_W        = TAN_W + 8;

    // square root
    localparam int SQ_W = 17;

    // output field widths
    localparam int ANGLE_W = 9;
    localparam int DIST_W  = 9;

    typedef logic [NUM_FIELDS-1:0][7:0] t_fields;

    typedef struct packed {
        logic    start;
        logic    last;
        t_fields fields;
    } t_frame;

    typedef struct packed {
        logic [7:0]         found;
        logic [ANGLE_W-1:0] angle;
        logic [DIST_W-1:0]  distance;
    } t_obj_result;

    typedef struct packed {
        logic                            done;
        logic                            busy;
        t_obj_result [NUM_OBJ-1:0]       result;
    } t_polar_status;

    // tan of the half-degree boundaries, unsigned q48, built at elaboration
    typedef logic [NUM_BOUNDS-1:0][TAN_W-1:0] t_tan_rom;

    localparam logic [63:0] PI_Q62       = 64'hC90FDAA22168C235;
    localparam logic [63:0] HALF_DEG_Q62 = PI_Q62 / 360;
    localparam logic [63:0] ONE_Q62      = 64'h1 << 62;
    localparam int SERIES_TERMS = 14;
    localparam logic [SERIES_TERMS-1:0][15:0] SIN_DIV = {
        16'd812, 16'd702, 16'd600, 16'd506, 16'd420, 16'd342, 16'd272,
        16'd210, 16'd156, 16'd110, 16'd72, 16'd42, 16'd20, 16'd6};
    localparam logic [SERIES_TERMS-1:0][15:0] COS_DIV = {
        16'd756, 16'd650, 16'd552, 16'd462, 16'd380, 16'd306, 16'd240,
        16'd182, 16'd132, 16'd90, 16'd56, 16'd30, 16'd12, 16'd2};

    // (a * b) >> 62 in q62
    function automatic logic [63:0] f_mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        return p[125:62];
    endfunction

    function automatic t_tan_rom f_build_tan_rom();
        t_tan_rom    rom;
        logic [63:0] th, t2, term, pos, neg, s, c, rem, q;
        rom = '0;
        for (int k = 0; k < NUM_BOUNDS; k++) begin
            th = 64'(HALF_DEG_Q62 * 64'(2 * k + 1));
            t2 = f_mul_q62(th, th);
            // sine series
            term = th;
            pos  = th;
            neg  = '0;
            for (int n = 0; n < SERIES_TERMS; n++) begin
                term = f_mul_q62(term, t2) / 64'(SIN_DIV[n]);
                if ((n % 2) == 0) neg = neg + term;
                else pos = pos + term;
            end
            s = pos - neg;
            // cosine series
            term = ONE_Q62;
            pos  = ONE_Q62;
            neg  = '0;
            for (int n = 0; n < SERIES_TERMS; n++) begin
                term = f_mul_q62(term, t2) / 64'(COS_DIV[n]);
                if ((n % 2) == 0) neg = neg + term;
                else pos = pos + term;
            end
            c = pos - neg;
            // restoring division s / c
            rem = s;
            q   = '0;
            for (int i = 0; i < 62; i++) begin
                rem = rem << 1;
                q   = q << 1;
                if (rem >= c) begin
                    rem = rem - c;
                    q   = q | 64'h1;
                end
            end
            rom[k] = TAN_W'((q + (64'h1 << 13)) >> 14);
        end
        return rom;
    endfunction

    localparam t_tan_rom TAN_ROM = f_build_tan_rom();

endpackage

@@ rtl/cbpd_sub.sv @@
// ---------------------------------------------------------------------------
// cbpd_sub
// shared subtract and compare unit for the bearing search and square root
// ---------------------------------------------------------------------------
module cbpd_sub (
    input  logic [cbpd_pkg::SUB_W-1:0] i_a,
    input  logic [cbpd_pkg::SUB_W-1:0] i_b,
    output logic [cbpd_pkg::SUB_W-1:0] o_diff,
    output logic                       o_borrow
);

    logic [cbpd_pkg::SUB_W:0] diff_full;

    // borrow is high when a < b
    assign diff_full = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff    = diff_full[cbpd_pkg::SUB_W-1:0];
    assign o_borrow  = diff_full[cbpd_pkg::SUB_W];

endmodule

@@ rtl/cbpd_parser.sv @@
// ---------------------------------------------------------------------------
// cbpd_parser
// hunts for the double begin byte and collects the frame fields
// ---------------------------------------------------------------------------
module cbpd_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    input  logic [7:0]           i_begin_marker,
    output cbpd_pkg::t_frame     o_frame
);

    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_ONE     = 3'b010,
        PH_COLLECT = 3'b100
    } t_phase;

    t_phase                       r_phase;
    logic [cbpd_pkg::IDX_W-1:0]   r_idx;
    logic                         r_start;
    cbpd_pkg::t_fields            r_fields;
    logic                         is_begin;
    logic                         is_last;

    assign is_begin = (i_byte == i_begin_marker);
    assign is_last  = (r_phase == PH_COLLECT) && (r_idx == cbpd_pkg::IDX_LAST);

    // phase and index sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_idx   <= '0;
            r_start <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (i_accept) begin
                unique case (r_phase)
                    PH_ONE: begin
                        if (is_begin) begin
                            r_phase <= PH_COLLECT;
                            r_idx   <= cbpd_pkg::IDX_W'(1);
                        end else begin
                            r_phase <= PH_HUNT;
                        end
                    end
                    PH_COLLECT: begin
                        if (is_last) begin
                            r_phase <= PH_HUNT;
                            r_idx   <= '0;
                            r_start <= 1'b1;
                        end else begin
                            r_idx <= r_idx + cbpd_pkg::IDX_W'(1);
                        end
                    end
                    default: begin
                        r_phase <= is_begin ? PH_ONE : PH_HUNT;
                    end
                endcase
            end
        end
    end

    // field capture, bytes one to nine of the frame
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < cbpd_pkg::NUM_FIELDS; j++) begin
            if (i_accept && (r_phase == PH_COLLECT) && (r_idx == cbpd_pkg::IDX_W'(j + 1))) begin
                r_fields[j] <= i_byte;
            end
        end
    end

    assign o_frame.start  = r_start;
    assign o_frame.last   = is_last;
    assign o_frame.fields = r_fields;

endmodule

@@ rtl/cbpd_polar.sv @@
// ---------------------------------------------------------------------------
// cbpd_polar
// sequencer converting three objects to bearing and distance in turn
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cbpd_polar (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  cbpd_pkg::t_frame        i_frame,
    input  logic [7:0]              i_centre_x,
    input  logic [7:0]              i_centre_y,
    output cbpd_pkg::t_polar_status o_status
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_LOAD = 7'b0000010,
        S_PREP = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_CMP  = 7'b0010000,
        S_SQRT = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    t_state                                    r_state;
    logic [1:0]                                r_obj;
    cbpd_pkg::t_fields                         r_fld;
    logic [7:0]                                r_ax, r_ay;
    logic                                      r_xneg, r_yneg, r_zero, r_swap;
    logic [7:0]                                r_num, r_den;
    logic [cbpd_pkg::BOUND_W-1:0]              r_lo, r_hi, r_mid;
    logic [cbpd_pkg::SUB_W-1:0]                r_prod;
    logic [cbpd_pkg::SQ_W-1:0]                 r_v, r_res, r_bit;
    cbpd_pkg::t_obj_result [cbpd_pkg::NUM_OBJ-1:0] r_result;
    logic                                      r_done;

    logic [8:0]                       dx, dy;
    logic [cbpd_pkg::BOUND_W:0]       mid_sum;
    logic [cbpd_pkg::BOUND_W-1:0]     mid;
    logic [cbpd_pkg::SQ_W:0]          sqrt_trial;
    logic [cbpd_pkg::SUB_W-1:0]       sub_a, sub_b, sub_diff;
    logic                             sub_borrow;
    logic [cbpd_pkg::BOUND_W-1:0]     lo_next, hi_next;
    logic [6:0]                       phi;
    logic [7:0]                       rr;
    logic [9:0]                       raw_ang, wrap_ang;
    logic [cbpd_pkg::ANGLE_W-1:0]     fin_angle;

    // centred coordinates of the object at the head of the field line
    assign dx = {1'b0, r_fld[1]} - {1'b0, i_centre_x};
    assign dy = {1'b0, r_fld[2]} - {1'b0, i_centre_y};

    // midpoint of the boundary search
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[cbpd_pkg::BOUND_W:1];

    assign sqrt_trial = {1'b0, r_res} + {1'b0, r_bit};

    // operand selection for the shared unit
    always_comb begin
        if (r_state == S_CMP) begin
            sub_a = r_prod;
            sub_b = {r_num, {cbpd_pkg::TAN_W{1'b0}}};
        end else begin
            sub_a = cbpd_pkg::SUB_W'(r_v);
            sub_b = cbpd_pkg::SUB_W'(sqrt_trial);
        end
    end

    cbpd_sub u_sub (
        .i_a      (sub_a),
        .i_b      (sub_b),
        .o_diff   (sub_diff),
        .o_borrow (sub_borrow)
    );

    // boundary below the ratio when the product is the smaller
    assign lo_next = sub_borrow ? (r_mid + cbpd_pkg::BOUND_W'(1)) : r_lo;
    assign hi_next = sub_borrow ? r_hi : r_mid;

    // fold the first-octant count back into a bearing
    always_comb begin
        phi = r_swap ? (7'(cbpd_pkg::QUARTER_TURN) - {1'b0, r_lo}) : {1'b0, r_lo};
        rr  = r_xneg ? (8'(cbpd_pkg::HALF_TURN) - {1'b0, phi}) : {1'b0, phi};
        raw_ang = r_yneg ? (10'(cbpd_pkg::ANGLE_OFFSET) + {2'b0, rr})
                         : (10'(cbpd_pkg::ANGLE_OFFSET) - {2'b0, rr});
        wrap_ang = (raw_ang >= 10'(cbpd_pkg::FULL_TURN)) ?
                   (raw_ang - 10'(cbpd_pkg::FULL_TURN)) : raw_ang;
        fin_angle = r_zero ? cbpd_pkg::ANGLE_W'(cbpd_pkg::QUARTER_TURN)
                           : wrap_ang[cbpd_pkg::ANGLE_W-1:0];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_obj   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_frame.start) begin
                        r_obj   <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: r_state <= S_PREP;
                S_PREP: r_state <= ((r_ax == 8'd0) && (r_ay == 8'd0)) ? S_FIN : S_MUL;
                S_MUL:  r_state <= S_CMP;
                S_CMP:  r_state <= (lo_next == hi_next) ? S_SQRT : S_MUL;
                S_SQRT: begin
                    if (r_bit == cbpd_pkg::SQ_W'(1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_obj == 2'(cbpd_pkg::NUM_OBJ - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_obj   <= r_obj + 2'd1;
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_frame.start) begin
                    r_fld <= i_frame.fields;
                end
            end
            S_LOAD: begin
                r_xneg <= dx[8];
                r_yneg <= dy[8];
                r_ax   <= dx[8] ? 8'(-dx) : dx[7:0];
                r_ay   <= dy[8] ? 8'(-dy) : dy[7:0];
            end
            S_PREP: begin
                r_zero <= (r_ax == 8'd0) && (r_ay == 8'd0);
                r_swap <= (r_ay > r_ax);
                r_num  <= (r_ay > r_ax) ? r_ax : r_ay;
                r_den  <= (r_ay > r_ax) ? r_ay : r_ax;
                r_v    <= {9'b0, r_ax} * {9'b0, r_ax} + {9'b0, r_ay} * {9'b0, r_ay};
                r_res  <= '0;
                r_bit  <= cbpd_pkg::SQ_W'(1) << (cbpd_pkg::SQ_W - 1);
                r_lo   <= '0;
                r_hi   <= cbpd_pkg::BOUND_W'(cbpd_pkg::NUM_BOUNDS);
            end
            S_MUL: begin
                r_mid  <= mid;
                r_prod <= {{cbpd_pkg::TAN_W{1'b0}}, r_den}
                          * cbpd_pkg::SUB_W'(cbpd_pkg::TAN_ROM[mid]);
            end
            S_CMP: begin
                r_lo <= lo_next;
                r_hi <= hi_next;
            end
            S_SQRT: begin
                if (!sub_borrow) begin
                    r_v   <= sub_diff[cbpd_pkg::SQ_W-1:0];
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            S_FIN: begin
                // results shift in at the top, first object ends at the bottom
                r_result[2].found    <= r_fld[0];
                r_result[2].angle    <= fin_angle;
                r_result[2].distance <= r_res[cbpd_pkg::DIST_W-1:0];
                r_result[1]          <= r_result[2];
                r_result[0]          <= r_result[1];
                r_fld                <= r_fld >> 24;
            end
            default: begin
            end
        endcase
    end

    assign o_status.done   = r_done;
    assign o_status.busy   = (r_state != S_IDLE);
    assign o_status.result = r_result;

    `CBPD_ASSERT(a_start_idle, i_clk, i_rst_n, i_frame.start |-> (r_state == S_IDLE), "frame start while converting")
    `CBPD_ASSERT(a_search_open, i_clk, i_rst_n, (r_state == S_CMP) |-> (r_lo < r_hi), "bearing search interval closed")
    `CBPD_ASSERT(a_sqrt_bit, i_clk, i_rst_n, (r_state == S_SQRT) |-> $onehot(r_bit), "root trial bit lost")
    `CBPD_ASSERT(a_angle_range, i_clk, i_rst_n, (r_state == S_FIN) |-> (fin_angle < 9'(cbpd_pkg::FULL_TURN)), "bearing out of range")

endmodule

@@ rtl/camera_blob_polar_decoder.sv @@
// ---------------------------------------------------------------------------
// camera_blob_polar_decoder
// camera frame parser with polar conversion of three tracked objects
// ---------------------------------------------------------------------------
// Bytes are taken one at a time whenever the input is not stalled. The byte
// that ends a frame starts the conversion of the three objects, each through
// a binary search of the bearing table (up to six multiply and compare rounds)
// and a nine-step square root, all on one shared subtractor, during which the
// input is stalled. The result item sits in an output register, so further
// bytes of the next frame are taken while it waits; only the byte that would
// finish another frame is held off until it has gone.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module camera_blob_polar_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // byte channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [7:0]                          i_rx_byte,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [7:0]                          o_blue_found,
    output logic [cbpd_pkg::ANGLE_W-1:0]        o_blue_angle,
    output logic [cbpd_pkg::DIST_W-1:0]         o_blue_distance,
    output logic [7:0]                          o_yellow_found,
    output logic [cbpd_pkg::ANGLE_W-1:0]        o_yellow_angle,
    output logic [cbpd_pkg::DIST_W-1:0]         o_yellow_distance,
    output logic [7:0]                          o_ball_found,
    output logic [cbpd_pkg::ANGLE_W-1:0]        o_ball_angle,
    output logic [cbpd_pkg::DIST_W-1:0]         o_ball_distance,
    // configuration port
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic [cbpd_pkg::APB_ADDR_W-1:0]     i_paddr,
    input  logic [cbpd_pkg::APB_DATA_W-1:0]     i_pwdata,
    output logic [cbpd_pkg::APB_DATA_W-1:0]     o_prdata,
    output logic                                o_pready
);

    logic [7:0]                                    r_begin_marker;
    logic [7:0]                                    r_centre_x;
    logic [7:0]                                    r_centre_y;
    logic                                          r_out_valid;
    cbpd_pkg::t_obj_result [cbpd_pkg::NUM_OBJ-1:0] r_out;

    cbpd_pkg::t_frame        frame;
    cbpd_pkg::t_polar_status st;
    logic                    in_accept;
    logic                    out_accept;
    logic                    cfg_write;
    logic [1:0]              reg_sel;

    assign reg_sel   = i_paddr[3:2];
    assign cfg_write = i_psel && i_penable && i_pwrite;
    assign o_pready  = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_begin_marker <= cbpd_pkg::BEGIN_RESET;
            r_centre_x     <= cbpd_pkg::CENTRE_X_RESET;
            r_centre_y     <= cbpd_pkg::CENTRE_Y_RESET;
        end else if (cfg_write) begin
            unique case (reg_sel)
                cbpd_pkg::REG_BEGIN:    r_begin_marker <= i_pwdata[7:0];
                cbpd_pkg::REG_CENTRE_X: r_centre_x     <= i_pwdata[7:0];
                cbpd_pkg::REG_CENTRE_Y: r_centre_y     <= i_pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (reg_sel)
            cbpd_pkg::REG_BEGIN:    o_prdata = cbpd_pkg::APB_DATA_W'(r_begin_marker);
            cbpd_pkg::REG_CENTRE_X: o_prdata = cbpd_pkg::APB_DATA_W'(r_centre_x);
            cbpd_pkg::REG_CENTRE_Y: o_prdata = cbpd_pkg::APB_DATA_W'(r_centre_y);
            default:                o_prdata = '0;
        endcase
    end

    // hold bytes while converting, and the frame end while a result waits
    assign o_in_stall = frame.start || st.busy || (frame.last && r_out_valid);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_accept = r_out_valid && !i_out_stall;

    cbpd_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_byte         (i_rx_byte),
        .i_begin_marker (r_begin_marker),
        .o_frame        (frame)
    );

    cbpd_polar u_polar (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_frame    (frame),
        .i_centre_x (r_centre_x),
        .i_centre_y (r_centre_y),
        .o_status   (st)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (st.done) begin
            r_out_valid <= 1'b1;
        end else if (out_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (st.done) begin
            r_out <= st.result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_blue_found      = r_out[0].found;
    assign o_blue_angle      = r_out[0].angle;
    assign o_blue_distance   = r_out[0].distance;
    assign o_yellow_found    = r_out[1].found;
    assign o_yellow_angle    = r_out[1].angle;
    assign o_yellow_distance = r_out[1].distance;
    assign o_ball_found      = r_out[2].found;
    assign o_ball_angle      = r_out[2].angle;
    assign o_ball_distance   = r_out[2].distance;

    `CBPD_ASSERT_NEVER(a_result_slot_free, i_clk, i_rst_n, st.done && r_out_valid, "result finished while output full")

endmodule
